[design/acd_pkg.sv]
// ----------------------------------------------------------------------------
// acd_pkg: shared types and constants for the advection-diffusion row step
// Widths, configuration layout, job record passed from front to back end, and
// the request format of the shared slice multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package acd_pkg;

	localparam int MAX_POINTS = 256;
	localparam int TOP_POINTS = (MAX_POINTS < 256) ? MAX_POINTS : 256;
	localparam int MIN_POINTS = 3;
	// first point index at which the three-point window is full
	localparam int FIRST_FULL = 2;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 8;
	localparam int GP_W      = IDX_W + 1;
	localparam int CFG_IDX_W = 3;

	localparam int GRID_RESET      = 256;
	localparam int ADV_COEFF_RESET = 65536;

	// job queue
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// slice multiplier: 64-bit signed multiplicand, 33-bit signed operand
	localparam int MX_W    = 64;
	localparam int MB_W    = DATA_W + 1;
	localparam int SLICE_W = 16;
	localparam int SLICES  = MX_W / SLICE_W;
	localparam int PP_W    = SLICE_W + 1 + MB_W;
	localparam int ACC_W   = 84;
	localparam int MCNT_W  = $clog2(SLICES + 1);

	localparam logic [CFG_IDX_W-1:0] REG_GRID_POINTS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADV_COEFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIF_COEFF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BND_MODE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_TERM   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TERM  = 3'd5;

	typedef enum logic [1:0] {
		BND_KEEP      = 2'd0,
		BND_DIRICHLET = 2'd1,
		BND_NEUMANN   = 2'd2,
		BND_PERIODIC  = 2'd3
	} bnd_mode_t;

	typedef struct packed {
		logic [GP_W-1:0]          grid_points;
		logic [DATA_W-1:0]        advection_coeff;
		logic [DATA_W-1:0]        diffusion_coeff;
		bnd_mode_t                boundary_mode;
		logic signed [DATA_W-1:0] left_edge_term;
		logic signed [DATA_W-1:0] right_edge_term;
	} cfg_t;

	typedef struct packed {
		logic emit_left;    // left edge at point 0 (keep or dirichlet)
		logic interior;     // window full, one new interior value
		logic first_fresh;  // this interior value is new value 1
		logic neu_left;     // neumann left edge follows new value 1
		logic per_left;     // periodic left edge at row end
		logic last;         // row ends with this point
	} job_flags_t;

	typedef struct packed {
		job_flags_t               flags;
		bnd_mode_t                mode;
		logic [IDX_W-1:0]         k;
		logic signed [DATA_W-1:0] conc;     // C[k]
		logic signed [DATA_W-1:0] conc_c;   // C[k-1]
		logic signed [DATA_W-1:0] conc_m;   // C[k-2]
		logic signed [DATA_W-1:0] vel_c;    // u[k-1]
		logic signed [DATA_W-1:0] vel_max;  // row maximum so far
	} job_t;

	typedef struct packed {
		logic                   start;
		logic signed [MX_W-1:0] x;
		logic signed [MB_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

[design/acd_queue.sv]
// ----------------------------------------------------------------------------
// acd_queue: short job queue between front and back end
// Flop-based fifo of job records; lets the front keep taking requests while
// the back end works on earlier points.
// ----------------------------------------------------------------------------
`default_nettype none

module acd_queue import acd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t head
);

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign full      = (count_q == Q_CW'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [Q_AW-1:0] ptr_next(input logic [Q_AW-1:0] p);
		return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[design/acd_mul.sv]
// ----------------------------------------------------------------------------
// acd_mul: shared slice multiplier
// Multiplies a 64-bit signed value by a 33-bit signed operand, one 16-bit
// slice per cycle from the top down, with a registered partial product.
// ----------------------------------------------------------------------------
`default_nettype none

module acd_mul import acd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mul_req_t                req,
	output logic                    done,
	output logic signed [ACC_W-1:0] product
);

	logic                    busy_q;
	logic                    done_q;
	logic [MCNT_W-1:0]       step_q;
	logic signed [MX_W-1:0]  x_q;
	logic signed [MB_W-1:0]  b_q;
	logic signed [PP_W-1:0]  pp_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SLICE_W:0] slice_op;

	// top slice carries the sign, the rest are unsigned
	always_comb begin
		if (step_q == '0) begin
			slice_op = {x_q[MX_W-1], x_q[MX_W-1 -: SLICE_W]};
		end else begin
			slice_op = {1'b0, x_q[MX_W-1 -: SLICE_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == MCNT_W'(SLICES)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.x;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= x_q << SLICE_W;
			pp_s1 <= slice_op * b_q;
			// accumulation adds each partial product in the cycle after it is registered
			if (step_q != '0) begin
				acc_q <= (acc_q <<< SLICE_W) + ACC_W'(pp_s1);
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

[design/acd_front.sv]
// ----------------------------------------------------------------------------
// acd_front: request intake and classification
// Keeps the three-point window, point counter and row velocity maximum, and
// turns each grid point into a job record; points with no result are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module acd_front import acd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] velocity,
	input  logic signed [DATA_W-1:0] conc_in,
	input  logic                     q_full,
	output logic                     q_push,
	output job_t                     q_data
);

	logic [IDX_W-1:0]         cnt_q;
	logic signed [DATA_W-1:0] older_q;
	logic signed [DATA_W-1:0] newer_q;
	logic signed [DATA_W-1:0] vel_c_q;
	logic signed [DATA_W-1:0] vmax_q;
	logic signed [DATA_W-1:0] vmax_new;
	logic [GP_W-1:0]          n_pts;
	logic                     accept;
	job_flags_t               flags;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (cfg.grid_points < GP_W'(MIN_POINTS)) begin
			n_pts = GP_W'(MIN_POINTS);
		end else if (cfg.grid_points > GP_W'(TOP_POINTS)) begin
			n_pts = GP_W'(TOP_POINTS);
		end else begin
			n_pts = cfg.grid_points;
		end
	end

	assign vmax_new = (velocity > vmax_q) ? velocity : vmax_q;

	always_comb begin
		flags.emit_left   = (cnt_q == '0) &&
			(cfg.boundary_mode == BND_KEEP || cfg.boundary_mode == BND_DIRICHLET);
		flags.interior    = (cnt_q >= IDX_W'(FIRST_FULL));
		flags.first_fresh = (cnt_q == IDX_W'(FIRST_FULL));
		flags.neu_left    = flags.first_fresh && (cfg.boundary_mode == BND_NEUMANN);
		// a point at or past the last index ends the row, also after a size change
		flags.last        = ({1'b0, cnt_q} >= (n_pts - GP_W'(1)));
		flags.per_left    = flags.last && (cfg.boundary_mode == BND_PERIODIC);
	end

	always_comb begin
		q_data.flags   = flags;
		q_data.mode    = cfg.boundary_mode;
		q_data.k       = cnt_q;
		q_data.conc    = conc_in;
		q_data.conc_c  = newer_q;
		q_data.conc_m  = older_q;
		q_data.vel_c   = vel_c_q;
		q_data.vel_max = vmax_new;
	end

	// the last point always has a full window, so it is always interior
	assign q_push = accept && (flags.emit_left || flags.interior);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			older_q <= '0;
			newer_q <= '0;
			vel_c_q <= '0;
			vmax_q  <= {1'b1, {(DATA_W-1){1'b0}}};
		end else if (accept) begin
			if (flags.last) begin
				cnt_q  <= '0;
				vmax_q <= {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				cnt_q  <= cnt_q + 1'b1;
				vmax_q <= vmax_new;
			end
			older_q <= newer_q;
			newer_q <= conc_in;
			vel_c_q <= velocity;
		end
	end

endmodule

`default_nettype wire

[design/acd_back.sv]
// ----------------------------------------------------------------------------
// acd_back: per-point arithmetic and result sequencing
// Pops jobs, runs the upwind, diffusion and stability products on the shared
// multiplier, and posts up to three results per job through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acd_back import acd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     q_not_empty,
	input  job_t                     q_head,
	output logic                     q_pop,
	output mul_req_t                 mul_req,
	input  logic                     mul_done,
	input  logic signed [ACC_W-1:0]  mul_product,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         point_index,
	output logic signed [DATA_W-1:0] conc_out,
	output logic                     last_of_run,
	output logic                     row_complete,
	output logic                     cfl_exceeded
);

	localparam int DIFF_W = DATA_W + 1;
	localparam int LAP_W  = DATA_W + 2;
	localparam int ADV_SH = 61;
	localparam int ADV_W  = ADV_SH + 2;
	localparam int DIF_W  = 51;
	localparam int SUM_W  = 64;

	localparam logic signed [ACC_W-1:0] ADV_HI  = ACC_W'(64'sd1 <<< ADV_SH);
	localparam logic signed [ACC_W-1:0] ADV_LO  = -ADV_HI;
	localparam logic signed [ACC_W-1:0] CFL_LIM = ACC_W'(64'sd1 <<< DATA_W);
	localparam logic signed [SUM_W-1:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [SUM_W-1:0] S32_MIN = -64'sd2147483648;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_LEFT   = 8'b0000_0010,
		ST_MSTART = 8'b0000_0100,
		ST_MWAIT  = 8'b0000_1000,
		ST_FRESH  = 8'b0001_0000,
		ST_NEUL   = 8'b0010_0000,
		ST_PERL   = 8'b0100_0000,
		ST_EDGE   = 8'b1000_0000
	} bk_state_t;

	typedef enum logic [1:0] {
		OP_SLOPE = 2'd0,
		OP_ADV   = 2'd1,
		OP_DIF   = 2'd2,
		OP_CFL   = 2'd3
	} mul_op_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[DATA_W-1:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	bk_state_t                state_q, state_d;
	mul_op_t                  op_q, op_d;
	job_t                     job_q;
	logic signed [MX_W-1:0]   slope_q;
	logic signed [ADV_W-1:0]  adv_q;
	logic signed [DIF_W-1:0]  dif_q;
	logic                     cfl_q;
	logic signed [DATA_W-1:0] fresh_q;
	logic signed [DATA_W-1:0] first_int_q;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     lor_q;
	logic                     rc_q;
	logic                     cfl_out_q;

	logic                     slot_free;
	logic signed [DIFF_W-1:0] slope_diff;
	logic signed [LAP_W-1:0]  lap;
	logic [DATA_W-1:0]        vmag;
	logic signed [ACC_W-1:0]  prod_shr;
	logic signed [ACC_W-1:0]  adv_clamped;
	logic signed [DATA_W-1:0] fresh_now;
	logic signed [DATA_W-1:0] left_val;
	logic signed [DATA_W-1:0] neul_val;
	logic signed [DATA_W-1:0] edge_val;

	logic                     post;
	logic [IDX_W-1:0]         post_idx;
	logic signed [DATA_W-1:0] post_val;
	logic                     post_lor;
	logic                     post_rc;

	assign slot_free = !out_valid_q || out_ready;

	// upwind difference picked by the sign of the centre velocity
	always_comb begin
		if (!job_q.vel_c[DATA_W-1]) begin
			slope_diff = DIFF_W'(job_q.conc_c) - DIFF_W'(job_q.conc_m);
		end else begin
			slope_diff = DIFF_W'(job_q.conc) - DIFF_W'(job_q.conc_c);
		end
	end

	assign lap  = LAP_W'(job_q.conc) - (LAP_W'(job_q.conc_c) <<< 1) + LAP_W'(job_q.conc_m);
	assign vmag = job_q.vel_max[DATA_W-1] ? DATA_W'(-job_q.vel_max) : job_q.vel_max;

	always_comb begin
		mul_req.start = (state_q == ST_MSTART);
		unique case (op_q)
			OP_SLOPE: begin
				mul_req.x = MX_W'(slope_diff);
				mul_req.b = MB_W'(job_q.vel_c);
			end
			OP_ADV: begin
				mul_req.x = slope_q;
				mul_req.b = {1'b0, cfg.advection_coeff};
			end
			OP_DIF: begin
				mul_req.x = MX_W'(lap);
				mul_req.b = {1'b0, cfg.diffusion_coeff};
			end
			OP_CFL: begin
				mul_req.x = {{(MX_W-DATA_W){1'b0}}, vmag};
				mul_req.b = {1'b0, cfg.advection_coeff};
			end
		endcase
	end

	// floor division by 2^16
	assign prod_shr = mul_product >>> SLICE_W;

	always_comb begin
		if (prod_shr > ADV_HI) begin
			adv_clamped = ADV_HI;
		end else if (prod_shr < ADV_LO) begin
			adv_clamped = ADV_LO;
		end else begin
			adv_clamped = prod_shr;
		end
	end

	assign fresh_now = sat32(SUM_W'(job_q.conc_c) - SUM_W'(adv_q) + SUM_W'(dif_q));
	assign left_val  = (job_q.mode == BND_KEEP) ? job_q.conc : cfg.left_edge_term;
	assign neul_val  = sat32(SUM_W'(fresh_q) - SUM_W'(cfg.left_edge_term));

	always_comb begin
		unique case (job_q.mode)
			BND_KEEP:      edge_val = job_q.conc;
			BND_DIRICHLET: edge_val = cfg.right_edge_term;
			BND_NEUMANN:   edge_val = sat32(SUM_W'(fresh_q) + SUM_W'(cfg.right_edge_term));
			BND_PERIODIC:  edge_val = first_int_q;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		q_pop    = 1'b0;
		post     = 1'b0;
		post_idx = '0;
		post_val = fresh_q;
		post_lor = 1'b0;
		post_rc  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_not_empty) begin
					q_pop   = 1'b1;
					state_d = ST_LEFT;
				end
			end
			ST_LEFT: begin
				post     = job_q.flags.emit_left && slot_free;
				post_val = left_val;
				post_lor = !job_q.flags.interior;
				if (!job_q.flags.emit_left || slot_free) begin
					op_d    = OP_SLOPE;
					state_d = job_q.flags.interior ? ST_MSTART : ST_IDLE;
				end
			end
			ST_MSTART: begin
				state_d = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (mul_done) begin
					unique case (op_q)
						OP_SLOPE: begin
							op_d    = OP_ADV;
							state_d = ST_MSTART;
						end
						OP_ADV: begin
							op_d    = OP_DIF;
							state_d = ST_MSTART;
						end
						OP_DIF: begin
							if (job_q.flags.last) begin
								op_d    = OP_CFL;
								state_d = ST_MSTART;
							end else begin
								state_d = ST_FRESH;
							end
						end
						OP_CFL: begin
							state_d = ST_FRESH;
						end
					endcase
				end
			end
			ST_FRESH: begin
				post     = slot_free;
				post_idx = job_q.k - 1'b1;
				post_val = fresh_now;
				post_lor = !(job_q.flags.neu_left || job_q.flags.last);
				if (slot_free) begin
					state_d = ST_NEUL;
				end
			end
			ST_NEUL: begin
				post     = job_q.flags.neu_left && slot_free;
				post_val = neul_val;
				post_lor = !job_q.flags.last;
				if (!job_q.flags.neu_left || slot_free) begin
					state_d = job_q.flags.last ? ST_PERL : ST_IDLE;
				end
			end
			ST_PERL: begin
				post     = job_q.flags.per_left && slot_free;
				post_val = fresh_q;
				if (!job_q.flags.per_left || slot_free) begin
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				post     = slot_free;
				post_idx = job_q.k;
				post_val = edge_val;
				post_lor = 1'b1;
				post_rc  = 1'b1;
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_SLOPE;
			out_valid_q <= 1'b0;
			first_int_q <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_FRESH && slot_free && job_q.flags.first_fresh) begin
				first_int_q <= fresh_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (state_q == ST_MWAIT && mul_done) begin
			unique case (op_q)
				OP_SLOPE: slope_q <= prod_shr[MX_W-1:0];
				OP_ADV:   adv_q   <= ADV_W'(adv_clamped);
				OP_DIF:   dif_q   <= prod_shr[DIF_W-1:0];
				OP_CFL:   cfl_q   <= (mul_product > CFL_LIM);
			endcase
		end
		if (state_q == ST_FRESH && slot_free) begin
			fresh_q <= fresh_now;
		end
		if (post) begin
			idx_q     <= post_idx;
			val_q     <= post_val;
			lor_q     <= post_lor;
			rc_q      <= post_rc;
			cfl_out_q <= post_rc && cfl_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_index  = idx_q;
	assign conc_out     = val_q;
	assign last_of_run  = lor_q;
	assign row_complete = rc_q;
	assign cfl_exceeded = cfl_out_q;

endmodule

`default_nettype wire

[design/advection_diffusion_row_step.sv]
// ----------------------------------------------------------------------------
// advection_diffusion_row_step: one explicit 1-D advection-diffusion time step
// Grid points of a row arrive in index order as (velocity, concentration)
// requests; new Q16.16 concentrations come out with their index, using a
// first-order upwind advection term and a central diffusion term, with edges
// set by the boundary mode and a stability flag on the row's last result. The
// front end takes one request per cycle until its two-entry job queue is full;
// the back end then handles one point at a time, and its time is set by the
// shared 17x33-bit slice multiplier, which takes each 64x33-bit product through
// a start step, four 16-bit slices, one partial-product stage and a done strobe.
// A left-edge-only point needs no product, an interior point three products,
// the last point of a row four products and up to two extra results, and the
// result side can stall any of them. Points with no result are dropped by the
// front end and never reach the back end. Configuration takes effect at once
// and should be written only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module advection_diffusion_row_step import acd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] velocity,
	input  logic signed [DATA_W-1:0] conc_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         point_index,
	output logic signed [DATA_W-1:0] conc_out,
	output logic                     last_of_run,
	output logic                     row_complete,
	output logic                     cfl_exceeded
);

	cfg_t                    cfg_q;
	logic                    q_push;
	job_t                    q_data;
	logic                    q_full;
	logic                    q_pop;
	logic                    q_not_empty;
	job_t                    q_head;
	mul_req_t                mul_req;
	logic                    mul_done;
	logic signed [ACC_W-1:0] mul_product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_points     <= GP_W'(GRID_RESET);
			cfg_q.advection_coeff <= DATA_W'(ADV_COEFF_RESET);
			cfg_q.diffusion_coeff <= '0;
			cfg_q.boundary_mode   <= BND_KEEP;
			cfg_q.left_edge_term  <= '0;
			cfg_q.right_edge_term <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GRID_POINTS: cfg_q.grid_points     <= cfg_data[GP_W-1:0];
				REG_ADV_COEFF:   cfg_q.advection_coeff <= cfg_data;
				REG_DIF_COEFF:   cfg_q.diffusion_coeff <= cfg_data;
				REG_BND_MODE:    cfg_q.boundary_mode   <= bnd_mode_t'(cfg_data[1:0]);
				REG_LEFT_TERM:   cfg_q.left_edge_term  <= cfg_data;
				REG_RIGHT_TERM:  cfg_q.right_edge_term <= cfg_data;
				default: ;
			endcase
		end
	end

	acd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.velocity (velocity),
		.conc_in  (conc_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_data)
	);

	acd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	acd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_product)
	);

	acd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.mul_req      (mul_req),
		.mul_done     (mul_done),
		.mul_product  (mul_product),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_index  (point_index),
		.conc_out     (conc_out),
		.last_of_run  (last_of_run),
		.row_complete (row_complete),
		.cfl_exceeded (cfl_exceeded)
	);

`ifndef SYNTH
	a_row_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_complete |-> last_of_run)
		else $error("row end result not marked as end of run");

	a_cfl_only_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_complete |-> !cfl_exceeded)
		else $error("stability flag outside row end");

	a_row_end_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_complete |-> point_index >= IDX_W'(FIRST_FULL))
		else $error("row ended before the window was full");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("job taken from empty queue");
`endif

endmodule

`default_nettype wire
